### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the conditioner checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/iqcbc_pkg.sv
// ----------------------------------------------------------------------------
// IQ conditioner package
// Widths, register codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package iqcbc_pkg;

   localparam int WORD_W    = 32;
   localparam int GAIN_W    = 16;
   localparam int DIV_W     = 27;
   localparam int BYTE_W    = 8;
   localparam int DC_W      = 64;
   localparam int ALU_W     = 70;
   localparam int CNT_W     = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0]  MUL_LAST  = CNT_W'(GAIN_W - 1);
   localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(BYTE_W - 1);
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd120;
   localparam logic [DIV_W-1:0]  DIV_RESET  = 27'd750;
   localparam logic [BYTE_W-1:0] BYTE_MID   = 8'd128;
   localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'd255;
   localparam logic [BYTE_W-1:0] BYTE_MIN   = 8'd0;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN    = 1'b0,
      CSR_AMP_DIV = 1'b1
   } csr_index_type;

   // Sequencer steps, run once for each channel.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_D1,
      ST_D2,
      ST_SUM1,
      ST_SUM2,
      ST_HALF,
      ST_DCERR,
      ST_DCUPD,
      ST_RESID,
      ST_MUL,
      ST_ABS,
      ST_CMP,
      ST_DIV,
      ST_BYTE
   } state_type;

   typedef struct packed {
      state_type        state;
      logic [CNT_W-1:0] cnt;
      logic             chan;
   } ctrl_type;

   typedef struct packed {
      logic [ALU_W-1:0] op_a;
      logic [ALU_W-1:0] op_b;
      logic             sub;
   } alu_op_type;

endpackage

### rtl/core/iqcbc_alu.sv
// ----------------------------------------------------------------------------
// IQ conditioner shared adder
// One wide add/subtract unit used by every step of the sequence except the byte pack.
// ----------------------------------------------------------------------------
module iqcbc_alu
   import iqcbc_pkg::*;
(
   input  alu_op_type       alu_op,
   output logic [ALU_W-1:0] alu_res
);

   // Subtraction is addition of the inverted operand plus one.
   assign alu_res = alu_op.op_a + (alu_op.sub ? ~alu_op.op_b : alu_op.op_b)
                    + {{(ALU_W-1){1'b0}}, alu_op.sub};

endmodule

### rtl/core/iqcbc_seq.sv
// ----------------------------------------------------------------------------
// IQ conditioner sequencer
// Steps both channels through difference, DC removal, multiply and divide.
// ----------------------------------------------------------------------------
module iqcbc_seq
   import iqcbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     out_busy,
   output ctrl_type ctrl
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             chan_ff, chan_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_D1;
         ST_D1:    state_in = ST_D2;
         ST_D2:    state_in = ST_SUM1;
         ST_SUM1:  state_in = ST_SUM2;
         ST_SUM2:  state_in = ST_HALF;
         ST_HALF:  state_in = ST_DCERR;
         ST_DCERR: state_in = ST_DCUPD;
         ST_DCUPD: state_in = ST_RESID;
         ST_RESID: state_in = ST_MUL;
         ST_MUL:   if (cnt_ff == MUL_LAST) state_in = ST_ABS;
         ST_ABS:   state_in = ST_CMP;
         ST_CMP:   state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == DIV_LAST) state_in = ST_BYTE;
         ST_BYTE: begin
            if (!chan_ff) begin
               state_in = ST_D1;
            end else if (!out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Iteration counter and channel select.
   always_comb begin
      cnt_in  = '0;
      chan_in = chan_ff;
      if (state_ff == ST_MUL || (state_ff == ST_DIV && cnt_ff != DIV_LAST)) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (state_ff == ST_BYTE) begin
         if (!chan_ff) begin
            chan_in = 1'b1;
         end else if (!out_busy) begin
            chan_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         chan_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chan_ff  <= chan_in;
      end
   end

   // Outputs.
   always_comb begin
      ctrl.state = state_ff;
      ctrl.cnt   = cnt_ff;
      ctrl.chan  = chan_ff;
   end

endmodule

### rtl/core/iq_counter_to_byte_conditioner.sv
// ----------------------------------------------------------------------------
// IQ counter-to-byte conditioner
// Turns counter word pairs into DC-free, scaled, saturated I/Q bytes.
// ----------------------------------------------------------------------------
// Each channel runs on the shared adder: 8 setup and DC steps,
// 16 shift-add multiply steps, 2 sign/compare steps, 8 divide steps, 1 pack.
// A new request is taken only once the block is idle again, after the previous
// result is registered, and later if rsp_stall holds the last result.
// Synchronous reset clears the history, the DC trackers and the handshakes,
// and loads gain = 120 and amplitude divisor = 750.
module iq_counter_to_byte_conditioner
   import iqcbc_pkg::*;
#(
   parameter int DC_SHIFT = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIV_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_W-1:0]    req_i_neg_first,
   input  logic [WORD_W-1:0]    req_i_pos_first,
   input  logic [WORD_W-1:0]    req_i_neg_second,
   input  logic [WORD_W-1:0]    req_i_pos_second,
   input  logic [WORD_W-1:0]    req_q_neg_first,
   input  logic [WORD_W-1:0]    req_q_pos_first,
   input  logic [WORD_W-1:0]    req_q_neg_second,
   input  logic [WORD_W-1:0]    req_q_pos_second,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_i_byte,
   output logic [BYTE_W-1:0]    rsp_q_byte
);

   ctrl_type         ctrl;
   alu_op_type       alu_op;
   logic [ALU_W-1:0] alu_res;
   logic             req_accept;
   logic             out_busy;
   logic             out_fire;

   logic [GAIN_W-1:0] gain_ff;
   logic [DIV_W-1:0]  div_ff;
   logic [DIV_W-1:0]  div_eff;

   logic [WORD_W-1:0] i_neg_first_ff, i_pos_first_ff, i_neg_second_ff, i_pos_second_ff;
   logic [WORD_W-1:0] q_neg_first_ff, q_pos_first_ff, q_neg_second_ff, q_pos_second_ff;
   logic [WORD_W-1:0] n1, p1, n2, p2;

   logic [WORD_W-1:0] prev_i_ff, prev_q_ff, prev_sel;
   logic [DC_W-1:0]   dc_i_ff, dc_q_ff, dc_sel;
   logic [ALU_W-1:0]  prev_ext, d1_ext, d2_ext, dc_ext, half_sum;

   logic [WORD_W-1:0] d1_ff, d2_ff;
   logic [ALU_W-1:0]  acc_ff, x_ff, m_ff;
   logic              neg_ff, sat_ff;
   logic [BYTE_W-1:0] q_ff, ib_ff, byte_val;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_i_byte_ff, rsp_q_byte_ff;

   iqcbc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .ctrl      (ctrl)
   );

   iqcbc_alu u_alu (
      .alu_op  (alu_op),
      .alu_res (alu_res)
   );

   // Handshakes.
   assign req_stall  = (ctrl.state != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign out_fire   = (ctrl.state == ST_BYTE) && ctrl.chan && !out_busy;

   // Configuration registers; a zero divisor acts as one.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         div_ff  <= DIV_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN:    gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_AMP_DIV: div_ff  <= csr_wdata;
            default:     ;
         endcase
      end
   end

   assign div_eff = (div_ff == '0) ? {{(DIV_W-1){1'b0}}, 1'b1} : div_ff;

   // Channel selection of the captured words and the per-channel state.
   always_comb begin
      n1       = ctrl.chan ? q_neg_first_ff  : i_neg_first_ff;
      p1       = ctrl.chan ? q_pos_first_ff  : i_pos_first_ff;
      n2       = ctrl.chan ? q_neg_second_ff : i_neg_second_ff;
      p2       = ctrl.chan ? q_pos_second_ff : i_pos_second_ff;
      prev_sel = ctrl.chan ? prev_q_ff : prev_i_ff;
      dc_sel   = ctrl.chan ? dc_q_ff   : dc_i_ff;
      prev_ext = {{(ALU_W-WORD_W){prev_sel[WORD_W-1]}}, prev_sel};
      d1_ext   = {{(ALU_W-WORD_W){d1_ff[WORD_W-1]}}, d1_ff};
      d2_ext   = {{(ALU_W-WORD_W){d2_ff[WORD_W-1]}}, d2_ff};
      dc_ext   = {{(ALU_W-DC_W){dc_sel[DC_W-1]}}, dc_sel};
      half_sum = ALU_W'($signed(alu_res) >>> 1);
   end

   // Operand selection for the shared adder.
   always_comb begin
      alu_op = '0;
      unique case (ctrl.state) inside
         ST_D1: begin
            alu_op.op_a = {{(ALU_W-WORD_W){1'b0}}, n1};
            alu_op.op_b = {{(ALU_W-WORD_W){1'b0}}, p1};
            alu_op.sub  = 1'b1;
         end
         ST_D2: begin
            alu_op.op_a = {{(ALU_W-WORD_W){1'b0}}, n2};
            alu_op.op_b = {{(ALU_W-WORD_W){1'b0}}, p2};
            alu_op.sub  = 1'b1;
         end
         ST_SUM1: begin
            alu_op.op_a = prev_ext;
            alu_op.op_b = d1_ext << 1;
         end
         ST_SUM2: begin
            alu_op.op_a = acc_ff;
            alu_op.op_b = d2_ext;
         end
         ST_HALF: begin
            // Adding one to a negative sum makes the halving round toward zero.
            alu_op.op_a = acc_ff;
            alu_op.op_b = {{(ALU_W-1){1'b0}}, acc_ff[ALU_W-1]};
         end
         ST_DCERR, ST_RESID: begin
            alu_op.op_a = x_ff;
            alu_op.op_b = dc_ext;
            alu_op.sub  = 1'b1;
         end
         ST_DCUPD: begin
            alu_op.op_a = dc_ext;
            alu_op.op_b = ALU_W'($signed(acc_ff) >>> DC_SHIFT);
         end
         ST_MUL: begin
            alu_op.op_a = acc_ff;
            alu_op.op_b = gain_ff[ctrl.cnt] ? m_ff : '0;
         end
         ST_ABS: begin
            alu_op.op_b = acc_ff;
            alu_op.sub  = acc_ff[ALU_W-1];
         end
         ST_CMP: begin
            alu_op.op_a = acc_ff;
            alu_op.op_b = {{(ALU_W-DIV_W-BYTE_W){1'b0}}, div_eff, {BYTE_W{1'b0}}};
            alu_op.sub  = 1'b1;
         end
         ST_DIV: begin
            alu_op.op_a = acc_ff;
            alu_op.op_b = m_ff;
            alu_op.sub  = 1'b1;
         end
         default: ;
      endcase
   end

   // Working registers of the sequence.
   always_ff @(posedge clock) begin
      case (ctrl.state)
         ST_IDLE: begin
            if (req_accept) begin
               i_neg_first_ff  <= req_i_neg_first;
               i_pos_first_ff  <= req_i_pos_first;
               i_neg_second_ff <= req_i_neg_second;
               i_pos_second_ff <= req_i_pos_second;
               q_neg_first_ff  <= req_q_neg_first;
               q_pos_first_ff  <= req_q_pos_first;
               q_neg_second_ff <= req_q_neg_second;
               q_pos_second_ff <= req_q_pos_second;
            end
         end
         ST_D1:    d1_ff  <= alu_res[WORD_W-1:0];
         ST_D2:    d2_ff  <= alu_res[WORD_W-1:0];
         ST_SUM1:  acc_ff <= alu_res;
         ST_SUM2:  acc_ff <= alu_res;
         ST_HALF:  x_ff   <= half_sum << DC_SHIFT;
         ST_DCERR: acc_ff <= alu_res;
         ST_RESID: begin
            m_ff   <= ALU_W'($signed(alu_res) >>> DC_SHIFT);
            acc_ff <= '0;
         end
         ST_MUL: begin
            acc_ff <= alu_res;
            m_ff   <= m_ff << 1;
         end
         ST_ABS: begin
            acc_ff <= alu_res;
            neg_ff <= acc_ff[ALU_W-1];
         end
         ST_CMP: begin
            // At or above 256 times the divisor the quotient saturates.
            sat_ff <= ~alu_res[ALU_W-1];
            m_ff   <= {{(ALU_W-DIV_W-BYTE_W+1){1'b0}}, div_eff, {(BYTE_W-1){1'b0}}};
            q_ff   <= '0;
         end
         ST_DIV: begin
            if (!alu_res[ALU_W-1]) begin
               acc_ff <= alu_res;
            end
            q_ff <= {q_ff[BYTE_W-2:0], ~alu_res[ALU_W-1]};
            m_ff <= m_ff >> 1;
         end
         ST_BYTE:  if (!ctrl.chan) ib_ff <= byte_val;
         default: ;
      endcase
   end

   // History and DC trackers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_i_ff <= '0;
         prev_q_ff <= '0;
         dc_i_ff   <= '0;
         dc_q_ff   <= '0;
      end else begin
         if (ctrl.state == ST_SUM2) begin
            if (ctrl.chan) prev_q_ff <= d2_ff;
            else           prev_i_ff <= d2_ff;
         end
         if (ctrl.state == ST_DCUPD) begin
            if (ctrl.chan) dc_q_ff <= alu_res[DC_W-1:0];
            else           dc_i_ff <= alu_res[DC_W-1:0];
         end
      end
   end

   // Signed saturation of the quotient, then the offset to unsigned.
   always_comb begin
      if (neg_ff) begin
         byte_val = (sat_ff || q_ff > BYTE_MID) ? BYTE_MIN : BYTE_MID - q_ff;
      end else begin
         byte_val = (sat_ff || q_ff[BYTE_W-1]) ? BYTE_MAX : {1'b1, q_ff[BYTE_W-2:0]};
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = out_fire || out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         rsp_i_byte_ff <= ib_ff;
         rsp_q_byte_ff <= byte_val;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_i_byte = rsp_i_byte_ff;
   assign rsp_q_byte = rsp_q_byte_ff;

endmodule

### rtl/core/iqcbc_checker.sv
// ----------------------------------------------------------------------------
// IQ conditioner checker
// Port-level assertions on request and result sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iqcbc_checker
   import iqcbc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_i_byte,
   input logic [BYTE_W-1:0] rsp_q_byte
);

   // A request keeps the block busy for the following cycle.
   `ASSERT_NEXT(a_busy_after_request, clock, reset, req_valid && !req_stall, req_stall, "request accepted on consecutive cycles")

   // A new result comes only out of a busy cycle.
   `ASSERT_IMPLIES(a_result_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "result appeared while idle")

   // When a result appears the block is ready for the next request.
   `ASSERT_IMPLIES(a_ready_with_result, clock, reset, $rose(rsp_valid), !req_stall, "block not ready after result")

   // A stalled result holds its value.
   `ASSERT_NEXT(a_result_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_i_byte) && $stable(rsp_q_byte), "stalled result changed")

endmodule

bind iq_counter_to_byte_conditioner iqcbc_checker u_iqcbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_i_byte (rsp_i_byte),
   .rsp_q_byte (rsp_q_byte)
);

### test/iq_counter_to_byte_conditioner_tb.sv
// ----------------------------------------------------------------------------
// IQ counter-to-byte conditioner testbench
// Drives counter word requests through the conditioner and checks every
// I/Q byte pair. A directed table covers the word extremes, counter wrap,
// zero gain, gain bits above the register, a zero divisor and the largest
// divisor. Randomized phases follow under changing register settings, with
// idle gaps on both channels and one long hold on the result side. Each
// result is compared against a typed byte pair from the table or an in-bench
// model of the DC tracker, the gain, the divide and the saturation.
// ----------------------------------------------------------------------------
module iq_counter_to_byte_conditioner_tb
   import iqcbc_pkg::*;
();

   localparam int DC_SHIFT        = 16;
   localparam int CHAN_I          = 0;
   localparam int CHAN_Q          = 1;
   localparam int BLOCK_LATENCY   = 71;
   localparam int RANDOM_PHASES   = 11;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int LONG_HOLD       = 600;
   localparam int WATCHDOG_LIMIT  = 5000;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] i_neg_first, i_pos_first, i_neg_second, i_pos_second;
      logic [WORD_W-1:0] q_neg_first, q_pos_first, q_neg_second, q_pos_second;
   } counter_set_type;

   typedef struct packed {
      logic [BYTE_W-1:0] i_byte;
      logic [BYTE_W-1:0] q_byte;
   } byte_pair_type;

   typedef struct packed {
      row_kind_type     kind;
      csr_index_type    csr_sel;
      logic [DIV_W-1:0] csr_value;
      counter_set_type  counters;
      logic             typed;
      byte_pair_type    typed_bytes;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   csr_index_type        csr_index;
   logic [DIV_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic [WORD_W-1:0]    req_i_neg_first;
   logic [WORD_W-1:0]    req_i_pos_first;
   logic [WORD_W-1:0]    req_i_neg_second;
   logic [WORD_W-1:0]    req_i_pos_second;
   logic [WORD_W-1:0]    req_q_neg_first;
   logic [WORD_W-1:0]    req_q_pos_first;
   logic [WORD_W-1:0]    req_q_neg_second;
   logic [WORD_W-1:0]    req_q_pos_second;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [BYTE_W-1:0]    rsp_i_byte;
   logic [BYTE_W-1:0]    rsp_q_byte;

   // Model state and register copies.
   logic [WORD_W-1:0] last_diff [2];
   longint            dc_est [2];
   longint            gain_setting;
   longint            divisor_setting;

   byte_pair_type expected_bytes [$];
   byte_pair_type arrived_pair;
   stim_row_type  directed_rows [$];
   int            mismatch_count;
   int            quiet_cycles;
   logic          tx_calm;
   logic          rx_calm;
   logic          long_hold_pending;

   iq_counter_to_byte_conditioner #(
      .DC_SHIFT(DC_SHIFT)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_i_neg_first  (req_i_neg_first),
      .req_i_pos_first  (req_i_pos_first),
      .req_i_neg_second (req_i_neg_second),
      .req_i_pos_second (req_i_pos_second),
      .req_q_neg_first  (req_q_neg_first),
      .req_q_pos_first  (req_q_pos_first),
      .req_q_neg_second (req_q_neg_second),
      .req_q_pos_second (req_q_pos_second),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_i_byte       (rsp_i_byte),
      .rsp_q_byte       (rsp_q_byte)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One channel of the conditioner: decimate, track DC, scale and saturate.
   function automatic logic [BYTE_W-1:0] condition_channel(input int ch,
         input logic [WORD_W-1:0] n1, input logic [WORD_W-1:0] p1,
         input logic [WORD_W-1:0] n2, input logic [WORD_W-1:0] p2);
      logic [WORD_W-1:0] diff_a;
      logic [WORD_W-1:0] diff_b;
      longint            d1;
      longint            d2;
      longint            sum;
      longint            scaled;
      longint            level;
      logic [63:0]       offset_level;
      diff_a = n1 - p1;
      diff_b = n2 - p2;
      d1 = longint'($signed(diff_a));
      d2 = longint'($signed(diff_b));
      sum = longint'($signed(last_diff[ch]));
      sum = sum + d1 + d1 + d2;
      last_diff[ch] = diff_b;
      // Halve toward zero, then lift to the tracker's fixed-point scale.
      scaled = (sum / 2) <<< DC_SHIFT;
      dc_est[ch] = dc_est[ch] + ((scaled - dc_est[ch]) >>> DC_SHIFT);
      level = (scaled - dc_est[ch]) >>> DC_SHIFT;
      level = level * gain_setting;
      level = level / ((divisor_setting == 0) ? 64'sd1 : divisor_setting);
      if (level > 127) begin
         level = 127;
      end else if (level < -128) begin
         level = -128;
      end
      offset_level = level + 128;
      return offset_level[BYTE_W-1:0];
   endfunction

   function automatic byte_pair_type predict_bytes(input counter_set_type w);
      byte_pair_type pair;
      pair.i_byte = condition_channel(CHAN_I, w.i_neg_first, w.i_pos_first,
                                      w.i_neg_second, w.i_pos_second);
      pair.q_byte = condition_channel(CHAN_Q, w.q_neg_first, w.q_pos_first,
                                      w.q_neg_second, w.q_pos_second);
      return pair;
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type sel,
                                            input logic [DIV_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr_sel = sel;
      row.csr_value = value;
      return row;
   endfunction

   function automatic stim_row_type request_row(input counter_set_type counters,
         input logic typed = 1'b0, input byte_pair_type bytes = '0);
      stim_row_type row;
      row = '0;
      row.kind = ROW_REQUEST;
      row.counters = counters;
      row.typed = typed;
      row.typed_bytes = bytes;
      return row;
   endfunction

   // Counter difference: mostly small around a bias, some medium, some wild.
   function automatic logic [WORD_W-1:0] counter_delta(input int bias);
      logic [WORD_W-1:0] delta;
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            delta = $urandom;
         end
         3, 4, 5, 6, 7: begin
            delta = WORD_W'($urandom_range(0, 1 << 21)) - (1 << 20) + bias;
         end
         default: begin
            delta = WORD_W'($urandom_range(0, 2000)) - 1000 + bias;
         end
      endcase
      return delta;
   endfunction

   function automatic counter_set_type random_counters(input int bias_i,
                                                       input int bias_q);
      counter_set_type c;
      c.i_pos_first  = $urandom;
      c.i_neg_first  = c.i_pos_first + counter_delta(bias_i);
      c.i_pos_second = $urandom;
      c.i_neg_second = c.i_pos_second + counter_delta(bias_i);
      c.q_pos_first  = $urandom;
      c.q_neg_first  = c.q_pos_first + counter_delta(bias_q);
      c.q_pos_second = $urandom;
      c.q_neg_second = c.q_pos_second + counter_delta(bias_q);
      return c;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_len(input logic calm);
      int pick;
      if (calm) begin
         return 0;
      end
      pick = $urandom_range(0, 15);
      if (pick < 8) begin
         return 0;
      end else if (pick < 14) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   // Offer one request after an optional gap and wait until it is taken.
   task automatic push_request(input counter_set_type w);
      int gap;
      gap = idle_len(tx_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_i_neg_first  <= w.i_neg_first;
      req_i_pos_first  <= w.i_pos_first;
      req_i_neg_second <= w.i_neg_second;
      req_i_pos_second <= w.i_pos_second;
      req_q_neg_first  <= w.q_neg_first;
      req_q_pos_first  <= w.q_pos_first;
      req_q_neg_second <= w.q_neg_second;
      req_q_pos_second <= w.q_pos_second;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop the request line and wait until every pending result is back.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [DIV_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (sel == CSR_GAIN) begin
         gain_setting = longint'(value[GAIN_W-1:0]);
      end else begin
         divisor_setting = longint'(value);
      end
   endtask

   // Result checking against the oldest expected byte pair.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: i_byte %0d, q_byte %0d", rsp_i_byte, rsp_q_byte);
            mismatch_count++;
         end else begin
            arrived_pair = expected_bytes.pop_front();
            if (rsp_i_byte !== arrived_pair.i_byte) begin
               $error("i_byte mismatch: expected %0d, actual %0d",
                      arrived_pair.i_byte, rsp_i_byte);
               mismatch_count++;
            end
            if (rsp_q_byte !== arrived_pair.q_byte) begin
               $error("q_byte mismatch: expected %0d, actual %0d",
                      arrived_pair.q_byte, rsp_q_byte);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a request or a result.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side pacing: random stall runs, calm stretches and one long hold.
   initial begin : result_pacing
      int   run_left;
      logic hold_done;
      run_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (run_left > 0) begin
            run_left--;
         end else if (long_hold_pending && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            run_left = LONG_HOLD - 1;
         end else if (rx_calm) begin
            rsp_stall <= 1'b0;
            run_left = $urandom_range(20, 100);
         end else if ($urandom_range(0, 1) == 0) begin
            rsp_stall <= 1'b0;
            run_left = $urandom_range(0, 7);
         end else begin
            rsp_stall <= 1'b1;
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 2);
         end
      end
   end

   initial begin : stimulus
      counter_set_type  words;
      byte_pair_type    pair;
      logic [DIV_W-1:0] gain_word;
      logic [DIV_W-1:0] div_word;
      int               bias_i;
      int               bias_q;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_GAIN;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_i_neg_first = '0;
      req_i_pos_first = '0;
      req_i_neg_second = '0;
      req_i_pos_second = '0;
      req_q_neg_first = '0;
      req_q_pos_first = '0;
      req_q_neg_second = '0;
      req_q_pos_second = '0;
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      long_hold_pending = 1'b0;
      gain_setting = longint'(GAIN_RESET);
      divisor_setting = longint'(DIV_RESET);
      last_diff[CHAN_I] = '0;
      last_diff[CHAN_Q] = '0;
      dc_est[CHAN_I] = 0;
      dc_est[CHAN_Q] = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: extremes, wrap, register masking and divisor corners.
      directed_rows = '{
         // Fresh state and zero input sit at mid scale.
         request_row('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
                     1'b1, '{8'd128, 8'd128}),
         // Largest positive I and most negative Q differences saturate.
         request_row('{32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0,
                       32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0},
                     1'b1, '{8'd255, 8'd0}),
         // Counters that wrap past zero.
         request_row('{32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}),
         request_row('{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000}),
         request_row('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}),
         request_row('{32'h1234_5678, 32'h1234_5600, 32'h0000_0010, 32'hFFFF_FFF0,
                       32'hDEAD_BEEF, 32'hDEAD_BF00, 32'h8000_0005, 32'h8000_0000}),
         // Sign flip against a saturated history.
         request_row('{32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0,
                       32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0}),
         // Zero gain pins both bytes at mid scale.
         csr_row(CSR_GAIN, 27'h0),
         request_row('{32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0,
                       32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0},
                     1'b1, '{8'd128, 8'd128}),
         // Bits above the gain register are dropped.
         csr_row(CSR_GAIN, 27'h7FF_FFFF),
         request_row('{32'd10, 32'd0, 32'd10, 32'd0, 32'd0, 32'd10, 32'd0, 32'd10}),
         request_row('{32'd3, 32'd2, 32'd1, 32'd2, 32'd2, 32'd3, 32'd2, 32'd1}),
         // A zero divisor acts as one.
         csr_row(CSR_GAIN, 27'd1),
         csr_row(CSR_AMP_DIV, 27'd0),
         request_row('{32'd100, 32'd0, 32'd90, 32'd0, 32'd0, 32'd100, 32'd0, 32'd50}),
         request_row('{32'd0, 32'd40, 32'd7, 32'd0, 32'd60, 32'd0, 32'd0, 32'd3}),
         request_row('{32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1, 32'd1}),
         // Largest divisor with largest gain.
         csr_row(CSR_AMP_DIV, 27'h7FF_FFFF),
         csr_row(CSR_GAIN, 27'h000_FFFF),
         request_row('{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000,
                       32'h0, 32'h7FFF_FFFF, 32'h1234_0000, 32'h0}),
         request_row('{32'h0, 32'h0, 32'h4000_0000, 32'h0,
                       32'h0, 32'h4000_0000, 32'h0, 32'h0}),
         csr_row(CSR_GAIN, DIV_W'(GAIN_RESET)),
         csr_row(CSR_AMP_DIV, DIV_RESET),
         request_row('{32'd500, 32'd0, 32'd500, 32'd0, 32'd0, 32'd500, 32'd0, 32'd500})
      };

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            settle_block();
            write_csr(directed_rows[r].csr_sel, directed_rows[r].csr_value);
         end else begin
            push_request(directed_rows[r].counters);
            pair = predict_bytes(directed_rows[r].counters);
            if (directed_rows[r].typed) begin
               pair = directed_rows[r].typed_bytes;
            end
            expected_bytes.push_back(pair);
         end
      end

      // Random phases, each under its own register setting and pacing.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_block();
         case ($urandom_range(0, 4))
            0: gain_word = '0;
            1: gain_word = DIV_W'(16'hFFFF);
            2: gain_word = DIV_W'(GAIN_RESET);
            3: gain_word = DIV_W'($urandom_range(1, 600));
            default: gain_word = DIV_W'($urandom);
         endcase
         // Bits above the register width must be ignored.
         gain_word[DIV_W-1:GAIN_W] = (DIV_W-GAIN_W)'($urandom);
         case ($urandom_range(0, 5))
            0: div_word = '0;
            1: div_word = DIV_W'(1);
            2: div_word = '1;
            3: div_word = DIV_RESET;
            4: div_word = DIV_W'($urandom_range(1, 75000000));
            default: div_word = DIV_W'($urandom_range(1, 2000));
         endcase
         write_csr(CSR_GAIN, gain_word);
         write_csr(CSR_AMP_DIV, div_word);
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         bias_i = $urandom_range(0, 4000) - 2000;
         bias_q = $urandom_range(0, 4000) - 2000;
         // Hold the result side for a long stretch while requests keep coming.
         if (phase == 2) begin
            long_hold_pending = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            words = random_counters(bias_i, bias_q);
            push_request(words);
            expected_bytes.push_back(predict_bytes(words));
         end
      end

      // Drain, then leave room for any stray result.
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (2 * BLOCK_LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
